/* design/ftfm_pkg.sv */
`default_nettype none

package ftfm_pkg;

  // default table depth
  localparam int MAX_RULES_DEF = 32;

  // width of the rule count seen on the result channel
  localparam int HELD_W = 6;

  // action codes
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_CHECK = 2'd2;

  // one stored rule
  typedef struct packed {
    logic        accept;
    logic        dport_wild;
    logic        sport_wild;
    logic        dst_ip_wild;
    logic        src_ip_wild;
    logic        proto_wild;
    logic [7:0]  proto;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
  } rule_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the input beat
    logic exec;     // apply clear or add, or open the scan
    logic scan;     // scan window is open
    logic publish;  // move the verdict into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_check;    // captured action is a check
    logic issue_more;  // rules remain to be read
    logic hit;         // rule under compare matches
  } stat_t;

endpackage

`default_nettype wire

/* design/ftfm_ctrl.sv */
`default_nettype none

module ftfm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire ftfm_pkg::stat_t st,
  output ftfm_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    SCAN,
    RESULT
  } state_t;

  state_t state;

  assign in_stall = (state != IDLE);

  always_comb begin
    cmd         = '0;
    cmd.load    = (state == IDLE) && in_valid;
    cmd.exec    = (state == EXEC);
    cmd.scan    = (state == SCAN);
    cmd.publish = (state == RESULT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) state <= EXEC;
        end
        EXEC: begin
          state <= st.is_check ? SCAN : RESULT;
        end
        SCAN: begin
          if (st.hit || !st.issue_more) state <= RESULT;
        end
        RESULT: begin
          if (cmd.publish) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/ftfm_dp.sv */
`default_nettype none

module ftfm_dp #(
  parameter int MAX_RULES = ftfm_pkg::MAX_RULES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ftfm_pkg::cmd_t                cmd,
  output ftfm_pkg::stat_t                    st,
  input  wire logic [1:0]                    action,
  input  wire logic [7:0]                    proto,
  input  wire logic [31:0]                   src_ip,
  input  wire logic [31:0]                   dst_ip,
  input  wire logic [15:0]                   sport,
  input  wire logic [15:0]                   dport,
  input  wire logic                          proto_wild,
  input  wire logic                          src_ip_wild,
  input  wire logic                          dst_ip_wild,
  input  wire logic                          sport_wild,
  input  wire logic                          dport_wild,
  input  wire logic                          rule_accept,
  output logic                               allow,
  output logic                               status,
  output logic [ftfm_pkg::HELD_W-1:0]        rules_held
);

  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_RULES);

  ftfm_pkg::rule_t mem [MAX_RULES];

  // captured beat
  logic [1:0]      act;
  ftfm_pkg::rule_t pkt;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd_addr;
  logic             rd_pend;
  ftfm_pkg::rule_t  rd_data;
  logic             allow_r;
  logic             status_r;

  logic             full;
  logic             wr_en;
  logic             rd_en;
  logic             match;
  logic [CNT_W+ftfm_pkg::HELD_W-1:0] count_ext;

  assign full  = (count == FULL_CNT);
  assign wr_en = cmd.exec && (act == ftfm_pkg::ACT_ADD) && !full;

  assign match = (rd_data.proto_wild    || (rd_data.proto    == pkt.proto))
              && (rd_data.src_ip_wild   || (rd_data.src_ip   == pkt.src_ip))
              && (rd_data.dst_ip_wild   || (rd_data.dst_ip   == pkt.dst_ip))
              && (rd_data.sport_wild    || (rd_data.sport    == pkt.sport))
              && (rd_data.dport_wild    || (rd_data.dport    == pkt.dport));

  always_comb begin
    st            = '0;
    st.is_check   = (act == ftfm_pkg::ACT_CHECK);
    st.issue_more = (rd_addr != count);
    st.hit        = rd_pend && match;
  end

  assign rd_en = cmd.scan && st.issue_more && !st.hit;

  assign count_ext = {{ftfm_pkg::HELD_W{1'b0}}, count};

  // rule store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[count[IDX_W-1:0]] <= pkt;
    if (rd_en) rd_data <= mem[rd_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      rd_addr <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      if (cmd.load) begin
        rd_addr <= '0;
      end else if (rd_en) begin
        rd_addr <= rd_addr + CNT_W'(1);
      end
      if (cmd.exec && (act == ftfm_pkg::ACT_CLEAR)) begin
        count <= '0;
      end else if (wr_en) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act               <= action;
      pkt.proto         <= proto;
      pkt.src_ip        <= src_ip;
      pkt.dst_ip        <= dst_ip;
      pkt.sport         <= sport;
      pkt.dport         <= dport;
      pkt.proto_wild    <= proto_wild;
      pkt.src_ip_wild   <= src_ip_wild;
      pkt.dst_ip_wild   <= dst_ip_wild;
      pkt.sport_wild    <= sport_wild;
      pkt.dport_wild    <= dport_wild;
      pkt.accept        <= rule_accept;
      allow_r           <= (action == ftfm_pkg::ACT_CHECK);
      status_r          <= 1'b0;
    end else begin
      if (cmd.exec && (act == ftfm_pkg::ACT_ADD) && full) status_r <= 1'b1;
      if (st.hit && cmd.scan) allow_r <= rd_data.accept;
    end
    if (cmd.publish) begin
      allow      <= allow_r;
      status     <= status_r;
      rules_held <= count_ext[ftfm_pkg::HELD_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* design/five_tuple_first_match_filter.sv */
`default_nettype none

// channel  direction  handshake              beat contents
// -------  ---------  ---------------------  ------------------------------------------
// in       into block in_valid / in_stall    action, five-tuple, wildcard flags, verdict
// out      from block out_valid / out_stall  allow, status, rules_held
//
// one beat at a time: capture, execute, then publish
// a clear or add goes from execute straight to publish; a check reads the rule memory once
// per cycle over its single read port, scanning up to rules_held rules in table order
// and ending early at the first matching rule
// in_stall is high from capture until the verdict is in the output register;
// a waiting result does not block the next capture
// reset clears the rule count and the handshake state; the rule memory is not cleared

module five_tuple_first_match_filter #(
  parameter int MAX_RULES = ftfm_pkg::MAX_RULES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             action,
  input  wire logic [7:0]             proto,
  input  wire logic [31:0]            src_ip,
  input  wire logic [31:0]            dst_ip,
  input  wire logic [15:0]            sport,
  input  wire logic [15:0]            dport,
  input  wire logic                   proto_wild,
  input  wire logic                   src_ip_wild,
  input  wire logic                   dst_ip_wild,
  input  wire logic                   sport_wild,
  input  wire logic                   dport_wild,
  input  wire logic                   rule_accept,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        allow,
  output logic                        status,
  output logic [ftfm_pkg::HELD_W-1:0] rules_held
);

  // rule count as seen on the result port when the table is full
  localparam logic [ftfm_pkg::HELD_W-1:0] FULL_HELD = ftfm_pkg::HELD_W'(MAX_RULES % 64);

  ftfm_pkg::cmd_t  cmd;
  ftfm_pkg::stat_t st;

  // sequencer: capture, execute, scan, publish
  ftfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // rule memory, compare logic, count and output register
  ftfm_dp #(
    .MAX_RULES (MAX_RULES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .action        (action),
    .proto         (proto),
    .src_ip        (src_ip),
    .dst_ip        (dst_ip),
    .sport         (sport),
    .dport         (dport),
    .proto_wild    (proto_wild),
    .src_ip_wild   (src_ip_wild),
    .dst_ip_wild   (dst_ip_wild),
    .sport_wild    (sport_wild),
    .dport_wild    (dport_wild),
    .rule_accept   (rule_accept),
    .allow         (allow),
    .status        (status),
    .rules_held    (rules_held)
  );

  // a refused add never comes with an allow verdict
  a_status_no_allow: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(allow && status))
    else $error("status and allow both set");

  // an add is refused only when the table is full
  a_full_refusal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (rules_held == FULL_HELD))
    else $error("add refused below full table");

  // one beat at a time: a capture closes the input channel
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after a capture");

endmodule

`default_nettype wire
